@@ src/setu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package setu_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int AW = $clog2(TABLE_DEPTH);
    // count must hold TABLE_DEPTH itself
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_W = 9;

    localparam int HANDLE_W = 16;
    localparam int PAGE_W = 16;
    localparam int BEAT_W = 2;
    localparam int LINE_W = 5;
    localparam int KEY_W = PAGE_W + BEAT_W + LINE_W;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        t_key                key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_REMOVE = 1'b1
    } t_func;

endpackage

`default_nettype wire

@@ src/setu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module setu_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 39
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ src/sorted_event_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sorted event table: entries are kept in one RAM in ascending order of
// {page, beat, line}; an insert goes in front of all entries with an equal
// or greater key, a remove deletes the lowest-indexed entry with a matching
// handle. Each transaction yields one result (status, position, count).
// Work walks the RAM one entry per cycle through its single read and write
// port. An insert walks down from the top, shifting each entry with an
// equal or greater key up by one as it goes; a remove walks up, shifting
// entries after the match down. A full-table insert, an insert into an
// empty table or a remove from an empty table goes straight to the done
// state. While the output register stays stalled, the result waits in the
// done state. One transaction is in flight at a time; the next may enter
// while the previous result is still waiting on the output register.
module sorted_event_table_unit
    import setu_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_func,
    input  wire logic [HANDLE_W-1:0] i_entry_handle,
    input  wire logic [PAGE_W-1:0]   i_page,
    input  wire logic [BEAT_W-1:0]   i_beat,
    input  wire logic [LINE_W-1:0]   i_line,

    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [1:0]               o_status,
    output logic [OUT_W-1:0]         o_position,
    output logic [OUT_W-1:0]         o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_REM,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_pos;
    logic                r_found;
    t_entry              r_new;
    t_status             r_res_status;
    logic [CW-1:0]       r_res_pos;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [OUT_W-1:0]    r_out_pos;
    logic [OUT_W-1:0]    r_out_count;

    logic                in_acc;
    t_entry              in_entry;
    t_entry              rd_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_entry              wr_data;
    logic                shift_up;
    logic                match;
    logic [CW-1:0]       idx_inc;
    logic                rem_last;

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc = i_in_valid && !o_in_stall;
    assign in_entry = '{handle: i_entry_handle, key: {i_page, i_beat, i_line}};

    // rd_data holds entry r_idx-1 in S_INS and entry r_idx in S_REM
    assign shift_up = (rd_data.key >= r_new.key);
    assign match = !r_found && (rd_data.handle == r_new.handle);
    assign idx_inc = r_idx + ONE_C;
    assign rem_last = (idx_inc >= r_count);

    setu_ram #(
        .DEPTH(TABLE_DEPTH),
        .WIDTH(ENTRY_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        rd_en = 1'b0;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = r_new;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func == FN_INSERT) begin
                        if (r_count == '0) begin
                            wr_en = 1'b1;
                            wr_data = in_entry;
                        end else if (r_count < DEPTH_C) begin
                            rd_en = 1'b1;
                            rd_addr = AW'(r_count - ONE_C);
                        end
                    end else if (r_count != '0) begin
                        rd_en = 1'b1;
                    end
                end
            end
            S_INS: begin
                wr_en = 1'b1;
                wr_addr = AW'(r_idx);
                if (shift_up) begin
                    wr_data = rd_data;
                    if (r_idx > ONE_C) begin
                        rd_en = 1'b1;
                        rd_addr = AW'(r_idx - TWO_C);
                    end
                end
            end
            S_PUT: begin
                wr_en = 1'b1;
                wr_addr = AW'(r_idx);
            end
            S_REM: begin
                if (r_found) begin
                    wr_en = 1'b1;
                    wr_addr = AW'(r_idx - ONE_C);
                    wr_data = rd_data;
                end
                if (!rem_last) begin
                    rd_en = 1'b1;
                    rd_addr = AW'(idx_inc);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE owns the output register in its own cycle
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_new <= in_entry;
                        r_res_pos <= '0;
                        if (i_func == FN_INSERT) begin
                            if (r_count >= DEPTH_C) begin
                                r_res_status <= ST_FULL;
                                r_state <= S_DONE;
                            end else if (r_count == '0) begin
                                r_count <= ONE_C;
                                r_res_status <= ST_INSERTED;
                                r_state <= S_DONE;
                            end else begin
                                r_idx <= r_count;
                                r_state <= S_INS;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_res_status <= ST_NOT_FOUND;
                                r_state <= S_DONE;
                            end else begin
                                r_idx <= '0;
                                r_found <= 1'b0;
                                r_state <= S_REM;
                            end
                        end
                    end
                end
                S_INS: begin
                    if (shift_up) begin
                        r_idx <= r_idx - ONE_C;
                        if (r_idx == ONE_C) begin
                            r_state <= S_PUT;
                        end
                    end else begin
                        r_count <= r_count + ONE_C;
                        r_res_status <= ST_INSERTED;
                        r_res_pos <= r_idx;
                        r_state <= S_DONE;
                    end
                end
                S_PUT: begin
                    r_count <= r_count + ONE_C;
                    r_res_status <= ST_INSERTED;
                    r_res_pos <= '0;
                    r_state <= S_DONE;
                end
                S_REM: begin
                    if (match) begin
                        r_found <= 1'b1;
                        r_pos <= r_idx;
                    end
                    r_idx <= idx_inc;
                    if (rem_last) begin
                        if (r_found || match) begin
                            r_count <= r_count - ONE_C;
                            r_res_status <= ST_REMOVED;
                            r_res_pos <= match ? r_idx : r_pos;
                        end else begin
                            r_res_status <= ST_NOT_FOUND;
                            r_res_pos <= '0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_pos <= OUT_W'(r_res_pos);
                        r_out_count <= OUT_W'(r_count);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_position = r_out_pos;
    assign o_entry_count = r_out_count;

endmodule

`default_nettype wire

@@ bench/sorted_event_table_unit_tb.sv @@
`timescale 1ns / 1ps

module sorted_event_table_unit_tb;
    import setu_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT = 4_000_000;
    // worst walk is a remove over a full table
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 64;
    localparam int MAX_SHOWN = 20;

    typedef struct {
        t_status              status;
        logic [OUT_W-1:0]     position;
        logic [OUT_W-1:0]     count;
    } t_op_result;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_func = FN_INSERT;
    logic [HANDLE_W-1:0] in_handle = '0;
    logic [PAGE_W-1:0]   in_page = '0;
    logic [BEAT_W-1:0]   in_beat = '0;
    logic [LINE_W-1:0]   in_line = '0;
    logic                out_stall = 1'b0;
    wire                 in_stall;
    wire                 out_valid;
    wire [1:0]           out_status;
    wire [OUT_W-1:0]     out_position;
    wire [OUT_W-1:0]     out_entry_count;

    t_entry     event_list[$];
    t_op_result pending_results[$];

    int send_idle_pct = 30;
    int recv_stall_pct = 86;
    int error_count = 0;
    int results_checked = 0;
    int n_inserted = 0;
    int n_removed = 0;
    int n_not_found = 0;
    int n_dropped = 0;
    int peak_depth = 0;
    longint cycle_count = 0;

    sorted_event_table_unit uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_func         (in_func),
        .i_entry_handle (in_handle),
        .i_page         (in_page),
        .i_beat         (in_beat),
        .i_line         (in_line),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (out_status),
        .o_position     (out_position),
        .o_entry_count  (out_entry_count)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_checked, what, got, want);
    endtask

    // Sorted insert / first-match remove on the shadow list; queues one result.
    function automatic void predict_table_op(t_func fn, logic [HANDLE_W-1:0] handle,
                                             logic [PAGE_W-1:0] page,
                                             logic [BEAT_W-1:0] beat,
                                             logic [LINE_W-1:0] ln);
        t_entry     item;
        t_op_result res;
        int         idx;
        item.handle = handle;
        item.key = {page, beat, ln};
        idx = 0;
        if (fn == FN_INSERT) begin
            if (event_list.size() >= TABLE_DEPTH) begin
                res.status = ST_FULL;
                n_dropped++;
            end else begin
                // equal keys: new entry goes in front
                while (idx < event_list.size() && item.key > event_list[idx].key)
                    idx++;
                event_list.insert(idx, item);
                res.status = ST_INSERTED;
                n_inserted++;
            end
        end else begin
            while (idx < event_list.size() && event_list[idx].handle != handle)
                idx++;
            if (idx < event_list.size()) begin
                event_list.delete(idx);
                res.status = ST_REMOVED;
                n_removed++;
            end else begin
                idx = 0;
                res.status = ST_NOT_FOUND;
                n_not_found++;
            end
        end
        res.position = OUT_W'(idx);
        res.count = OUT_W'(event_list.size());
        if (event_list.size() > peak_depth)
            peak_depth = event_list.size();
        pending_results.push_back(res);
    endfunction

    task automatic send_op(t_func fn, logic [HANDLE_W-1:0] handle, logic [PAGE_W-1:0] page,
                           logic [BEAT_W-1:0] beat, logic [LINE_W-1:0] ln);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_func <= fn;
        in_handle <= handle;
        in_page <= page;
        in_beat <= beat;
        in_line <= ln;
        do
            @(posedge clk);
        while (in_stall);
        predict_table_op(fn, handle, page, beat, ln);
    endtask

    always @(posedge clk) begin
        t_op_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction, status", int'(out_status), -1);
            end else begin
                want = pending_results.pop_front();
                if (out_status !== want.status)
                    report_mismatch("status", int'(out_status), int'(want.status));
                if (out_position !== want.position)
                    report_mismatch("position", int'(out_position), int'(want.position));
                if (out_entry_count !== want.count)
                    report_mismatch("entry_count", int'(out_entry_count), int'(want.count));
            end
            results_checked++;
        end
    end

    task automatic test_empty_table();
        send_op(FN_REMOVE, 16'h0000, 16'h0000, 2'd0, 5'd0);
        send_op(FN_REMOVE, 16'hFFFF, 16'hFFFF, 2'd3, 5'd31);
    endtask

    task automatic test_key_order();
        send_op(FN_INSERT, 16'h0001, 16'h8000, 2'd2, 5'd16);
        send_op(FN_INSERT, 16'hFFFF, 16'hFFFF, 2'd3, 5'd31);
        send_op(FN_INSERT, 16'h0000, 16'h0000, 2'd0, 5'd0);
        // equal keys land in front of the older entry
        send_op(FN_INSERT, 16'h1234, 16'h8000, 2'd2, 5'd16);
        send_op(FN_INSERT, 16'h0002, 16'hFFFF, 2'd3, 5'd31);
        send_op(FN_INSERT, 16'h0003, 16'h0000, 2'd0, 5'd0);
        // duplicate handle, next key up
        send_op(FN_INSERT, 16'h0001, 16'h8000, 2'd2, 5'd17);
        send_op(FN_INSERT, 16'h5555, 16'h8000, 2'd1, 5'd31);
        send_op(FN_INSERT, 16'hAAAA, 16'h8000, 2'd3, 5'd0);
        send_op(FN_INSERT, 16'h00FF, 16'h7FFF, 2'd3, 5'd31);
        send_op(FN_REMOVE, 16'h0001, 16'h0000, 2'd0, 5'd0);
        send_op(FN_REMOVE, 16'h0001, 16'h0000, 2'd0, 5'd0);
        send_op(FN_REMOVE, 16'h0001, 16'h0000, 2'd0, 5'd0);
        send_op(FN_REMOVE, 16'hFFFF, 16'hFFFF, 2'd3, 5'd31);
        send_op(FN_REMOVE, 16'h0000, 16'h0000, 2'd0, 5'd0);
        send_op(FN_REMOVE, 16'h1234, 16'h0000, 2'd0, 5'd0);
        send_op(FN_REMOVE, 16'h0002, 16'h0000, 2'd0, 5'd0);
        send_op(FN_REMOVE, 16'h0003, 16'h0000, 2'd0, 5'd0);
        send_op(FN_REMOVE, 16'h5555, 16'h0000, 2'd0, 5'd0);
        send_op(FN_REMOVE, 16'hAAAA, 16'h0000, 2'd0, 5'd0);
        send_op(FN_REMOVE, 16'h00FF, 16'h0000, 2'd0, 5'd0);
    endtask

    task automatic test_table_full();
        int k;
        int idx;
        for (k = 0; k < TABLE_DEPTH; k++)
            send_op(FN_INSERT, HANDLE_W'(k), PAGE_W'($urandom_range(15)),
                    BEAT_W'($urandom_range(3)), LINE_W'($urandom_range(31)));
        send_op(FN_INSERT, 16'hBEEF, 16'h0000, 2'd0, 5'd0);
        send_op(FN_INSERT, 16'hBEEF, 16'hFFFF, 2'd3, 5'd31);
        send_op(FN_REMOVE, 16'hFFFF, 16'h0000, 2'd0, 5'd0);
        send_op(FN_REMOVE, HANDLE_W'(TABLE_DEPTH / 2), 16'h0000, 2'd0, 5'd0);
        send_op(FN_INSERT, 16'hBEEF, 16'h0007, 2'd1, 5'd9);
        send_op(FN_INSERT, 16'hCAFE, 16'h0007, 2'd1, 5'd9);
        // drain in random order
        while (event_list.size() > 0) begin
            idx = $urandom_range(event_list.size() - 1);
            send_op(FN_REMOVE, event_list[idx].handle, PAGE_W'($urandom()),
                    BEAT_W'($urandom()), LINE_W'($urandom()));
        end
    endtask

    task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
        int                  k;
        int                  depth_cap;
        int                  idx;
        t_func               fn;
        logic [HANDLE_W-1:0] handle;
        logic [PAGE_W-1:0]   page;
        logic [BEAT_W-1:0]   beat;
        logic [LINE_W-1:0]   ln;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        depth_cap = 16;
        for (k = 0; k < n_items; k++) begin
            // target depth changes every hundred transactions; mostly shallow
            if (k % 100 == 0) begin
                case ($urandom_range(5))
                    0: depth_cap = 4;
                    1: depth_cap = 16;
                    2: depth_cap = 40;
                    3: depth_cap = 96;
                    4: depth_cap = 200;
                    default: depth_cap = 24;
                endcase
            end
            if (event_list.size() < depth_cap)
                fn = ($urandom_range(99) < 70) ? FN_INSERT : FN_REMOVE;
            else
                fn = ($urandom_range(99) < 25) ? FN_INSERT : FN_REMOVE;
            handle = HANDLE_W'($urandom());
            page = PAGE_W'($urandom());
            beat = BEAT_W'($urandom());
            ln = LINE_W'($urandom());
            if (fn == FN_INSERT) begin
                if (event_list.size() > 0 && $urandom_range(3) == 0)
                    handle = event_list[$urandom_range(event_list.size() - 1)].handle;
                case ($urandom_range(3))
                    0: ;
                    1, 2: page = PAGE_W'($urandom_range(3));
                    default: begin
                        if (event_list.size() > 0) begin
                            idx = $urandom_range(event_list.size() - 1);
                            {page, beat, ln} = event_list[idx].key;
                        end
                    end
                endcase
            end else if (event_list.size() > 0 && $urandom_range(4) != 0) begin
                handle = event_list[$urandom_range(event_list.size() - 1)].handle;
            end
            send_op(fn, handle, page, beat, ln);
        end
    endtask

    task automatic finish_run();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d inserts, %0d removes, %0d misses, %0d full drops",
                 n_inserted, n_removed, n_not_found, n_dropped);
        $display("%0d results checked, peak depth %0d of %0d, %0d mismatches",
                 results_checked, peak_depth, TABLE_DEPTH, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_key_order();
        test_table_full();
        test_random_traffic(320, 30, 86);
        test_random_traffic(320, 86, 30);
        test_random_traffic(320, 0, 0);
        finish_run();
    end

endmodule
